### hw/rtl/lcd_window_pixel_byte_emitter_macros.svh
// ----------------------------------------------------------------------------
// LCD window/pixel byte emitter assertion macros
// Shorthand for clocked, reset-qualified properties used by the RTL files.
// ----------------------------------------------------------------------------
`ifndef LCD_WINDOW_PIXEL_BYTE_EMITTER_MACROS_SVH
`define LCD_WINDOW_PIXEL_BYTE_EMITTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LWPBE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LWPBE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lwpbe_pkg.sv
// ----------------------------------------------------------------------------
// lwpbe_pkg
// Shared types, command codes, format codes and colour scale table.
// ----------------------------------------------------------------------------
package lwpbe_pkg;

	// Controller commands
	localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
	localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
	localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

	// Config register indexes
	localparam logic [2:0] REG_PANEL_FORMAT  = 3'd0;
	localparam logic [2:0] REG_SOURCE_FORMAT = 3'd1;
	localparam logic [2:0] REG_BLUE_FIRST    = 3'd2;
	localparam logic [2:0] REG_COLUMN_OFFSET = 3'd3;
	localparam logic [2:0] REG_ROW_OFFSET    = 3'd4;

	// Panel pixel formats
	localparam logic [1:0] PANEL_666 = 2'd0;
	localparam logic [1:0] PANEL_565 = 2'd1;
	localparam logic [1:0] PANEL_444 = 2'd2;

	// Source colour scales
	localparam logic [2:0] SRC_8BIT = 3'd0;
	localparam logic [2:0] SRC_PCT  = 3'd1;
	localparam logic [2:0] SRC_666  = 3'd2;
	localparam logic [2:0] SRC_565  = 3'd3;
	localparam logic [2:0] SRC_444  = 3'd4;

	localparam int QUEUE_DEPTH = 4;

	// floor(x / d) == (x * ceil(2^22 / d)) >> 22 for x < 2^14, d <= 255
	localparam int SCALE_SHIFT = 22;
	localparam int K_W         = 25;
	localparam int PROD_W      = SCALE_SHIFT + 8;
	localparam int R_255 = (2**SCALE_SHIFT + 254) / 255;
	localparam int R_100 = (2**SCALE_SHIFT + 99) / 100;
	localparam int R_63  = (2**SCALE_SHIFT + 62) / 63;
	localparam int R_31  = (2**SCALE_SHIFT + 30) / 31;
	localparam int R_15  = (2**SCALE_SHIFT + 14) / 15;

	typedef enum logic [1:0] {
		TOP_63,
		TOP_31,
		TOP_15
	} top_cls_t;

	typedef enum logic [2:0] {
		DIV_255,
		DIV_100,
		DIV_63,
		DIV_31,
		DIV_15
	} div_cls_t;

	// scale factor = panel_max * reciprocal(source_max)
	localparam logic [K_W-1:0] SCALE_TAB [3][5] = '{
		'{K_W'(63 * R_255), K_W'(63 * R_100), K_W'(63 * R_63), K_W'(63 * R_31),
		  K_W'(63 * R_15)},
		'{K_W'(31 * R_255), K_W'(31 * R_100), K_W'(31 * R_63), K_W'(31 * R_31),
		  K_W'(31 * R_15)},
		'{K_W'(15 * R_255), K_W'(15 * R_100), K_W'(15 * R_63), K_W'(15 * R_31),
		  K_W'(15 * R_15)}
	};

	typedef struct packed {
		logic [1:0] panel_format;
		logic [2:0] source_format;
		logic       blue_first;
		logic [7:0] column_offset;
		logic [7:0] row_offset;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_WINDOW,
		KIND_PIXEL3,
		KIND_PIXEL2
	} kind_t;

	// Window: col start, col end, row start, row end (offsets applied).
	// Pixel: bytes in send order from index 0.
	typedef struct packed {
		kind_t           kind;
		logic [3:0][7:0] bytes;
	} entry_t;

endpackage

### hw/rtl/lwpbe_front.sv
// ----------------------------------------------------------------------------
// lwpbe_front
// Accepts items, applies offsets or scales the colour, and queues a job.
// ----------------------------------------------------------------------------
module lwpbe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  lwpbe_pkg::cfg_t    cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [7:0]         col_start,
	input  logic [7:0]         row_start,
	input  logic [7:0]         col_end,
	input  logic [7:0]         row_end,
	input  logic [23:0]        pixel_colour,
	input  logic               q_full,
	output logic               q_push,
	output lwpbe_pkg::entry_t  q_data
);

	localparam int PW = lwpbe_pkg::PROD_W;
	localparam int SH = lwpbe_pkg::SCALE_SHIFT;

	logic [1:0] pf_eff;
	logic [2:0] sf_eff;
	logic       pass;
	lwpbe_pkg::top_cls_t top_rb, top_g;
	lwpbe_pkg::div_cls_t div_rb, div_g;
	logic [lwpbe_pkg::K_W-1:0] k_rb, k_g;
	logic accept;

	logic          valid_s1;
	logic          action_s1;
	logic [7:0]    cs_s1, ce_s1, rs_s1, re_s1;
	logic [23:0]   colour_s1;
	logic          pass_s1;
	logic [1:0]    pf_s1;
	logic [PW-1:0] prod_r_s1, prod_g_s1, prod_b_s1;

	logic [7:0]  r, g, b, r_sw, b_sw;
	logic [31:0] word;

	// unused codes fold onto 5-6-5 and 8-bit
	assign pf_eff = (cfg.panel_format > lwpbe_pkg::PANEL_444) ?
		lwpbe_pkg::PANEL_565 : cfg.panel_format;
	assign sf_eff = (cfg.source_format > lwpbe_pkg::SRC_444) ?
		lwpbe_pkg::SRC_8BIT : cfg.source_format;
	// source codes 2..4 line up with panel codes 0..2
	assign pass = ({1'b0, pf_eff} + 3'd2) == sf_eff;

	always_comb begin
		unique case (pf_eff)
			lwpbe_pkg::PANEL_666: begin
				top_rb = lwpbe_pkg::TOP_63;
				top_g  = lwpbe_pkg::TOP_63;
			end
			lwpbe_pkg::PANEL_565: begin
				top_rb = lwpbe_pkg::TOP_31;
				top_g  = lwpbe_pkg::TOP_63;
			end
			default: begin
				top_rb = lwpbe_pkg::TOP_15;
				top_g  = lwpbe_pkg::TOP_15;
			end
		endcase
		unique case (sf_eff)
			lwpbe_pkg::SRC_PCT: begin
				div_rb = lwpbe_pkg::DIV_100;
				div_g  = lwpbe_pkg::DIV_100;
			end
			lwpbe_pkg::SRC_666: begin
				div_rb = lwpbe_pkg::DIV_63;
				div_g  = lwpbe_pkg::DIV_63;
			end
			lwpbe_pkg::SRC_565: begin
				div_rb = lwpbe_pkg::DIV_31;
				div_g  = lwpbe_pkg::DIV_63;
			end
			lwpbe_pkg::SRC_444: begin
				div_rb = lwpbe_pkg::DIV_15;
				div_g  = lwpbe_pkg::DIV_15;
			end
			default: begin
				div_rb = lwpbe_pkg::DIV_255;
				div_g  = lwpbe_pkg::DIV_255;
			end
		endcase
	end

	assign k_rb = lwpbe_pkg::SCALE_TAB[top_rb][div_rb];
	assign k_g  = lwpbe_pkg::SCALE_TAB[top_g][div_g];

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			cs_s1     <= col_start + cfg.column_offset;
			ce_s1     <= col_end + cfg.column_offset;
			rs_s1     <= row_start + cfg.row_offset;
			re_s1     <= row_end + cfg.row_offset;
			colour_s1 <= pixel_colour;
			pass_s1   <= pass;
			pf_s1     <= pf_eff;
			prod_r_s1 <= PW'(pixel_colour[23:16]) * PW'(k_rb);
			prod_g_s1 <= PW'(pixel_colour[15:8]) * PW'(k_g);
			prod_b_s1 <= PW'(pixel_colour[7:0]) * PW'(k_rb);
		end
	end

	// quotient, low 8 bits kept
	assign r = prod_r_s1[SH +: 8];
	assign g = prod_g_s1[SH +: 8];
	assign b = prod_b_s1[SH +: 8];
	assign r_sw = cfg.blue_first ? b : r;
	assign b_sw = cfg.blue_first ? r : b;

	always_comb begin
		if (pass_s1) begin
			word = 32'(colour_s1);
		end else begin
			unique case (pf_s1)
				lwpbe_pkg::PANEL_666:
					word = (32'(r_sw) << 18) | (32'(g) << 10) | (32'(b_sw) << 2);
				lwpbe_pkg::PANEL_565:
					word = (32'(r_sw) << 11) | (32'(g) << 5) | 32'(b_sw);
				default:
					word = (32'(r_sw) << 8) | (32'(g) << 4) | 32'(b_sw);
			endcase
		end
	end

	always_comb begin
		q_data.kind  = lwpbe_pkg::KIND_WINDOW;
		q_data.bytes = '0;
		if (!action_s1) begin
			q_data.bytes = {re_s1, rs_s1, ce_s1, cs_s1};
		end else if (pf_s1 == lwpbe_pkg::PANEL_666) begin
			q_data.kind  = lwpbe_pkg::KIND_PIXEL3;
			q_data.bytes = {8'h00, word[7:0], word[15:8], word[23:16]};
		end else begin
			q_data.kind  = lwpbe_pkg::KIND_PIXEL2;
			q_data.bytes = {16'h0000, word[7:0], word[15:8]};
		end
	end

endmodule

### hw/rtl/lwpbe_fifo.sv
// ----------------------------------------------------------------------------
// lwpbe_fifo
// Small job queue between the front and back; head readable in place.
// ----------------------------------------------------------------------------
module lwpbe_fifo #(
	parameter int Depth = lwpbe_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lwpbe_pkg::entry_t  push_data,
	input  logic               pop,
	output lwpbe_pkg::entry_t  head,
	output logic               full,
	output logic               empty
);

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W = $clog2(Depth + 1);

	lwpbe_pkg::entry_t mem_q [Depth];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(Depth - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = count_q == CNT_W'(Depth);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/lwpbe_back.sv
// ----------------------------------------------------------------------------
// lwpbe_back
// Walks the job at the queue head and emits one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`include "lcd_window_pixel_byte_emitter_macros.svh"

module lwpbe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lwpbe_pkg::entry_t  head,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               is_command,
	output logic               last
);

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       is_command_q, last_q;
	logic       load;
	logic [7:0] nb_byte;
	logic       nb_cmd, nb_last;

	assign load  = !q_empty && (!out_valid_q || !out_stall);
	assign q_pop = load && nb_last;

	always_comb begin
		nb_byte = 8'h00;
		nb_cmd  = 1'b0;
		nb_last = 1'b0;
		unique case (head.kind)
			lwpbe_pkg::KIND_WINDOW: begin
				unique case (idx_q)
					4'd0: begin
						nb_byte = lwpbe_pkg::CMD_COLUMN_SET;
						nb_cmd  = 1'b1;
					end
					4'd2: nb_byte = head.bytes[0];
					4'd4: nb_byte = head.bytes[1];
					4'd5: begin
						nb_byte = lwpbe_pkg::CMD_ROW_SET;
						nb_cmd  = 1'b1;
					end
					4'd7: nb_byte = head.bytes[2];
					4'd9: nb_byte = head.bytes[3];
					4'd10: begin
						nb_byte = lwpbe_pkg::CMD_MEMORY_WRITE;
						nb_cmd  = 1'b1;
						nb_last = 1'b1;
					end
					default: nb_byte = 8'h00;	// high address bytes
				endcase
			end
			lwpbe_pkg::KIND_PIXEL3: begin
				nb_byte = head.bytes[idx_q[1:0]];
				nb_last = idx_q == 4'd2;
			end
			lwpbe_pkg::KIND_PIXEL2: begin
				nb_byte = head.bytes[idx_q[1:0]];
				nb_last = idx_q == 4'd1;
			end
			default: nb_last = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= nb_last ? 4'd0 : idx_q + 4'd1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= nb_byte;
			is_command_q <= nb_cmd;
			last_q       <= nb_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign is_command = is_command_q;
	assign last       = last_q;

	`LWPBE_ASSERT_IMP(a_job_held, idx_q != 4'd0, !q_empty, "job left queue mid-item")
	`LWPBE_ASSERT_NXT(a_job_continues, load && !q_pop, idx_q != 4'd0, "byte index lost")

endmodule

### hw/rtl/lcd_window_pixel_byte_emitter.sv
// ----------------------------------------------------------------------------
// lcd_window_pixel_byte_emitter
// Command/data byte stream for a small SPI TFT controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one item per handshake. action 0
//   opens a drawing window and produces eleven bytes (column-set, four
//   address bytes, row-set, four address bytes, memory-write). action 1
//   sends one pixel colour: three bytes on a 6-6-6 panel, two otherwise.
//   Output channel (out_valid/out_stall): one byte per handshake with its
//   command/data flag and a last flag on the final byte of each item.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
//   only while the block is idle.
//   An accepted item passes the front stage register and the job queue;
//   its bytes leave from the output register of the byte sequencer, one
//   byte per cycle while the receiver does not stall. The job queue lets
//   new items enter while bytes drain.
//   A stalled receiver holds the output byte; once the queue fills the
//   input channel stalls. Reset empties the pipeline and queue and loads
//   the register reset values (5-6-5 panel, 8-bit source).
// ----------------------------------------------------------------------------
`include "lcd_window_pixel_byte_emitter_macros.svh"

module lcd_window_pixel_byte_emitter #(
	parameter int QUEUE_DEPTH = lwpbe_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// items in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  col_start,
	input  logic [7:0]  row_start,
	input  logic [7:0]  col_end,
	input  logic [7:0]  row_end,
	input  logic [23:0] pixel_colour,
	// bytes out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        is_command,
	output logic        last
);

	lwpbe_pkg::cfg_t   cfg_q;
	lwpbe_pkg::entry_t q_wdata, q_head;
	logic q_push, q_pop, q_full, q_empty;
	logic known_cmd;

	assign cfg_ready = 1'b1;

	// Config registers; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_format  <= lwpbe_pkg::PANEL_565;
			cfg_q.source_format <= lwpbe_pkg::SRC_8BIT;
			cfg_q.blue_first    <= 1'b0;
			cfg_q.column_offset <= 8'h00;
			cfg_q.row_offset    <= 8'h00;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lwpbe_pkg::REG_PANEL_FORMAT:  cfg_q.panel_format  <= cfg_data[1:0];
				lwpbe_pkg::REG_SOURCE_FORMAT: cfg_q.source_format <= cfg_data[2:0];
				lwpbe_pkg::REG_BLUE_FIRST:    cfg_q.blue_first    <= cfg_data[0];
				lwpbe_pkg::REG_COLUMN_OFFSET: cfg_q.column_offset <= cfg_data;
				lwpbe_pkg::REG_ROW_OFFSET:    cfg_q.row_offset    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: offsets and colour scaling, one registered stage.
	lwpbe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.col_start    (col_start),
		.row_start    (row_start),
		.col_end      (col_end),
		.row_end      (row_end),
		.pixel_colour (pixel_colour),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	// Jobs wait here until the back end has loaded their last byte into its output register.
	lwpbe_fifo #(
		.Depth (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Back: byte sequencer with output register.
	lwpbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.is_command (is_command),
		.last       (last)
	);

	// command flag only ever marks one of the three controller commands
	assign known_cmd = (out_byte == lwpbe_pkg::CMD_COLUMN_SET) ||
		(out_byte == lwpbe_pkg::CMD_ROW_SET) ||
		(out_byte == lwpbe_pkg::CMD_MEMORY_WRITE);

	`LWPBE_ASSERT_IMP(a_cmd_code, out_valid && is_command, known_cmd, "bad command byte")
	`LWPBE_ASSERT_IMP(a_gap_after_last, $fell(out_valid), $past(last), "output gap inside an item")

endmodule

### test/tb_lcd_window_pixel_byte_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_window_pixel_byte_emitter
// Self-checking bench for the window/pixel byte emitter. A directed table
// covers reset values, coordinate wrap, several format pairs, passthrough and
// unused codes. Random phases with fresh register settings follow. Every
// output byte is checked against a local model of the command/data stream,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_lcd_window_pixel_byte_emitter;

	// spare indexes of the config channel
	localparam logic [2:0] REG_SPARE_FIRST   = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST    = 3'd7;

	// panel code with no format of its own (acts as 5-6-5)
	localparam logic [1:0] PANEL_SPARE = 2'd3;
	// source code with no scale of its own (acts as 8-bit)
	localparam logic [2:0] SRC_SPARE = 3'd7;

	localparam logic ACT_WINDOW = 1'b0;
	localparam logic ACT_PIXEL  = 1'b1;

	// channel maxima of the colour scales
	localparam int MAX_8BIT = 255;
	localparam int MAX_PCT  = 100;
	localparam int MAX_6BIT = 63;
	localparam int MAX_5BIT = 31;
	localparam int MAX_4BIT = 15;

	localparam int CLK_PERIOD       = 4;
	localparam int RESET_CYCLES     = 12;
	localparam int RANDOM_ITEMS     = 90;
	localparam int QUIET_TAIL_ITEMS = 20;
	localparam int PRESSURE_ITEMS   = 20;
	localparam int LONG_HOLD        = 80;
	localparam int SETTLE_CYCLES    = 4;
	localparam int TAIL_CYCLES      = 20;
	localparam int WATCHDOG_LIMIT   = 2000;

	typedef struct {
		logic [7:0] data;
		logic       cmd;
		logic       fin;
	} lcd_byte_t;

	// one step of the directed table: a register write or an item
	typedef struct {
		logic             is_cfg;
		logic [2:0]       reg_idx;
		logic [7:0]       reg_data;
		logic             act;
		logic [7:0]       cs;
		logic [7:0]       rs;
		logic [7:0]       ce;
		logic [7:0]       re;
		logic [23:0]      colour;
		int               n_typed;   // 0: bytes come from the model below
		logic [0:10][7:0] typed;
	} plan_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index    = '0;
	logic [7:0]  cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic        action       = 1'b0;
	logic [7:0]  col_start    = '0;
	logic [7:0]  row_start    = '0;
	logic [7:0]  col_end      = '0;
	logic [7:0]  row_end      = '0;
	logic [23:0] pixel_colour = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [7:0]  out_byte;
	logic        is_command;
	logic        last;

	lcd_window_pixel_byte_emitter uut (.*);

	// local copy of the registers, updated on each accepted write
	lwpbe_pkg::cfg_t cur_cfg = '{panel_format: lwpbe_pkg::PANEL_565,
	                             source_format: lwpbe_pkg::SRC_8BIT,
	                             blue_first: 1'b0, column_offset: 8'd0,
	                             row_offset: 8'd0};
	lcd_byte_t bytes_due[$];
	plan_row_t plan[$];
	int        n_errors     = 0;
	int        quiet_cycles = 0;
	int        items_sent   = 0;
	int        stall_left   = 0;
	bit        no_idle      = 1'b0;
	bit        hold_request = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Colour model: per-channel floor scale, low 8 bits kept, optional
	// red/blue swap, then packing. Overflowing channels spill into the
	// neighbor's bits by OR. Matching formats pass the word through raw.
	// ------------------------------------------------------------------
	function automatic logic [31:0] convert_colour(input logic [23:0] colour,
			input logic [1:0] pf, input logic [2:0] sf, input logic swap);
		int          top_r, top_g, top_b, div_r, div_g, div_b;
		int          rc, gc, bc;
		logic [31:0] r, g, b, t;
		if (int'(sf) == int'(pf) + 2)
			return {8'h00, colour};
		rc = colour[23:16];
		gc = colour[15:8];
		bc = colour[7:0];
		unique case (pf)
			lwpbe_pkg::PANEL_666: begin
				top_r = MAX_6BIT; top_g = MAX_6BIT; top_b = MAX_6BIT;
			end
			lwpbe_pkg::PANEL_565: begin
				top_r = MAX_5BIT; top_g = MAX_6BIT; top_b = MAX_5BIT;
			end
			default: begin
				top_r = MAX_4BIT; top_g = MAX_4BIT; top_b = MAX_4BIT;
			end
		endcase
		unique case (sf)
			lwpbe_pkg::SRC_PCT: begin
				div_r = MAX_PCT; div_g = MAX_PCT; div_b = MAX_PCT;
			end
			lwpbe_pkg::SRC_666: begin
				div_r = MAX_6BIT; div_g = MAX_6BIT; div_b = MAX_6BIT;
			end
			lwpbe_pkg::SRC_565: begin
				div_r = MAX_5BIT; div_g = MAX_6BIT; div_b = MAX_5BIT;
			end
			lwpbe_pkg::SRC_444: begin
				div_r = MAX_4BIT; div_g = MAX_4BIT; div_b = MAX_4BIT;
			end
			default: begin
				div_r = MAX_8BIT; div_g = MAX_8BIT; div_b = MAX_8BIT;
			end
		endcase
		r = 32'((rc * top_r / div_r) & 'hFF);
		g = 32'((gc * top_g / div_g) & 'hFF);
		b = 32'((bc * top_b / div_b) & 'hFF);
		if (swap) begin
			t = r; r = b; b = t;
		end
		unique case (pf)
			lwpbe_pkg::PANEL_666: return (r << 18) | (g << 10) | (b << 2);
			lwpbe_pkg::PANEL_565: return (r << 11) | (g << 5) | b;
			default:              return (r << 8) | (g << 4) | b;
		endcase
	endfunction

	function automatic void push_byte(input logic [7:0] data, input logic cmd);
		lcd_byte_t nb;
		nb.data = data;
		nb.cmd  = cmd;
		nb.fin  = 1'b0;
		bytes_due.push_back(nb);
	endfunction

	// Expected byte stream of one item under the current registers.
	function automatic void predict_bytes(input logic act, input logic [7:0] cs,
			input logic [7:0] rs, input logic [7:0] ce, input logic [7:0] re,
			input logic [23:0] colour);
		logic [1:0]  pf;
		logic [2:0]  sf;
		logic [31:0] word;
		// unused codes fall back to 5-6-5 panel / 8-bit source
		pf = (cur_cfg.panel_format == PANEL_SPARE) ? lwpbe_pkg::PANEL_565 :
			cur_cfg.panel_format;
		sf = (cur_cfg.source_format > lwpbe_pkg::SRC_444) ? lwpbe_pkg::SRC_8BIT :
			cur_cfg.source_format;
		if (act == ACT_WINDOW) begin
			push_byte(lwpbe_pkg::CMD_COLUMN_SET, 1'b1);
			push_byte(8'h00, 1'b0);
			push_byte(cs + cur_cfg.column_offset, 1'b0);
			push_byte(8'h00, 1'b0);
			push_byte(ce + cur_cfg.column_offset, 1'b0);
			push_byte(lwpbe_pkg::CMD_ROW_SET, 1'b1);
			push_byte(8'h00, 1'b0);
			push_byte(rs + cur_cfg.row_offset, 1'b0);
			push_byte(8'h00, 1'b0);
			push_byte(re + cur_cfg.row_offset, 1'b0);
			push_byte(lwpbe_pkg::CMD_MEMORY_WRITE, 1'b1);
		end else begin
			word = convert_colour(colour, pf, sf, cur_cfg.blue_first);
			if (pf == lwpbe_pkg::PANEL_666)
				push_byte(word[23:16], 1'b0);
			push_byte(word[15:8], 1'b0);
			push_byte(word[7:0], 1'b0);
		end
		bytes_due[bytes_due.size() - 1].fin = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Table rows and random picks
	// ------------------------------------------------------------------
	function automatic plan_row_t cfg_row(input logic [2:0] idx, input logic [7:0] data);
		plan_row_t row;
		row          = '{default: '0};
		row.is_cfg   = 1'b1;
		row.reg_idx  = idx;
		row.reg_data = data;
		return row;
	endfunction

	function automatic plan_row_t item_row(input logic act, input logic [7:0] cs,
			input logic [7:0] rs, input logic [7:0] ce, input logic [7:0] re,
			input logic [23:0] colour, input int n_typed, input logic [0:10][7:0] typed);
		plan_row_t row;
		row         = '{default: '0};
		row.act     = act;
		row.cs      = cs;
		row.rs      = rs;
		row.ce      = ce;
		row.re      = re;
		row.colour  = colour;
		row.n_typed = n_typed;
		row.typed   = typed;
		return row;
	endfunction

	// mostly a legal code, sometimes with junk in the unused upper bits
	function automatic logic [7:0] reg_value(input logic [7:0] mask);
		logic [7:0] v;
		v = 8'($urandom);
		return ($urandom_range(0, 3) == 0) ? v : (v & mask);
	endfunction

	// coordinates and offsets: the ends of the range now and then
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	// colour channel: extremes, values inside the source scale, or anything
	function automatic logic [7:0] pick_channel();
		int lim;
		unique case (cur_cfg.source_format)
			lwpbe_pkg::SRC_PCT: lim = MAX_PCT;
			lwpbe_pkg::SRC_666: lim = MAX_6BIT;
			lwpbe_pkg::SRC_565: lim = MAX_6BIT;
			lwpbe_pkg::SRC_444: lim = MAX_4BIT;
			default:            lim = MAX_8BIT;
		endcase
		unique case ($urandom_range(0, 3))
			0: begin
				unique case ($urandom_range(0, 2))
					0: return 8'h00;
					1: return 8'hFF;
					default: return 8'(lim);
				endcase
			end
			1: return 8'($urandom_range(0, lim));
			default: return 8'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sender side: everything driven on the falling edge, handshakes
	// judged at the rising edge.
	// ------------------------------------------------------------------
	task automatic idle_sender();
		int gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic offer_item(input logic act, input logic [7:0] cs, input logic [7:0] rs,
			input logic [7:0] ce, input logic [7:0] re, input logic [23:0] colour,
			input int n_typed, input logic [0:10][7:0] typed);
		@(negedge clk);
		in_valid     <= 1'b1;
		action       <= act;
		col_start    <= cs;
		row_start    <= rs;
		col_end      <= ce;
		row_end      <= re;
		pixel_colour <= colour;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// item taken at this edge: queue what it has to produce
		if (n_typed == 0) begin
			predict_bytes(act, cs, rs, ce, re, colour);
		end else begin
			// typed rows: windows carry commands at bytes 0, 5 and 10
			for (int k = 0; k < n_typed; k++)
				push_byte(typed[k], (act == ACT_WINDOW) && (k == 0 || k == 5 || k == 10));
			bytes_due[bytes_due.size() - 1].fin = 1'b1;
		end
		items_sent++;
	endtask

	// stop offering and let every queued byte come out
	task automatic drain_stream();
		@(negedge clk);
		in_valid <= 1'b0;
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		unique case (idx)
			lwpbe_pkg::REG_PANEL_FORMAT:  cur_cfg.panel_format  = data[1:0];
			lwpbe_pkg::REG_SOURCE_FORMAT: cur_cfg.source_format = data[2:0];
			lwpbe_pkg::REG_BLUE_FIRST:    cur_cfg.blue_first    = data[0];
			lwpbe_pkg::REG_COLUMN_OFFSET: cur_cfg.column_offset = data;
			lwpbe_pkg::REG_ROW_OFFSET:    cur_cfg.row_offset    = data;
			default: ;   // spare indexes hold nothing
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver side: random stall bursts, plus one long hold-off when the
	// sender asks for it. One value of out_stall per falling edge.
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD - 1;
				out_stall   <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Output checker: each byte against the oldest expected one.
	always @(posedge clk) begin : check_out
		lcd_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bytes_due.size() == 0) begin
				$error("out_byte: nothing expected, actual %h", out_byte);
				n_errors++;
			end else begin
				want = bytes_due.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte: expected %h, actual %h", want.data, out_byte);
					n_errors++;
				end
				if (is_command !== want.cmd) begin
					$error("is_command: expected %b, actual %b", want.cmd, is_command);
					n_errors++;
				end
				if (last !== want.fin) begin
					$error("last: expected %b, actual %b", want.fin, last);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: too long without any handshake means the block hung.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int n_directed;
		int burst;
		int phase;
		plan_row_t row;

		// reset values: 5-6-5 panel, 8-bit source, no offsets
		plan.push_back(item_row(ACT_WINDOW, 8'h00, 8'h00, 8'hFF, 8'hFF, 24'hFFFFFF, 11,
			{lwpbe_pkg::CMD_COLUMN_SET, 8'h00, 8'h00, 8'h00, 8'hFF,
			 lwpbe_pkg::CMD_ROW_SET, 8'h00, 8'h00, 8'h00, 8'hFF,
			 lwpbe_pkg::CMD_MEMORY_WRITE}));
		plan.push_back(item_row(ACT_PIXEL, 8'hFF, 8'hFF, 8'h00, 8'h00, 24'hFFFFFF, 2,
			{8'hFF, 8'hFF, 72'h0}));
		plan.push_back(item_row(ACT_PIXEL, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 24'h000000, 2,
			{8'h00, 8'h00, 72'h0}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'h123456, 0, '0));
		// offsets that wrap past 255
		plan.push_back(cfg_row(lwpbe_pkg::REG_COLUMN_OFFSET, 8'hFF));
		plan.push_back(cfg_row(lwpbe_pkg::REG_ROW_OFFSET, 8'h01));
		plan.push_back(item_row(ACT_WINDOW, 8'h01, 8'hFF, 8'hFF, 8'h00, 24'h000000, 11,
			{lwpbe_pkg::CMD_COLUMN_SET, 8'h00, 8'h00, 8'h00, 8'hFE,
			 lwpbe_pkg::CMD_ROW_SET, 8'h00, 8'h00, 8'h00, 8'h01,
			 lwpbe_pkg::CMD_MEMORY_WRITE}));
		// 6-6-6 panel, three bytes per pixel
		plan.push_back(cfg_row(lwpbe_pkg::REG_PANEL_FORMAT, {6'd0, lwpbe_pkg::PANEL_666}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'hFFFFFF, 3,
			{8'hFC, 8'hFC, 8'hFC, 64'h0}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'hA55AC3, 0, '0));
		// percent source: 100 hits full scale, above 100 overflows
		plan.push_back(cfg_row(lwpbe_pkg::REG_SOURCE_FORMAT, {5'd0, lwpbe_pkg::SRC_PCT}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'h646464, 3,
			{8'hFC, 8'hFC, 8'hFC, 64'h0}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'hFFFFFF, 0, '0));
		// same format on both sides: raw passthrough
		plan.push_back(cfg_row(lwpbe_pkg::REG_SOURCE_FORMAT, {5'd0, lwpbe_pkg::SRC_666}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'h123456, 3,
			{8'h12, 8'h34, 8'h56, 64'h0}));
		// swap with an upscaling source, spilling into neighbors
		plan.push_back(cfg_row(lwpbe_pkg::REG_BLUE_FIRST, 8'h01));
		plan.push_back(cfg_row(lwpbe_pkg::REG_SOURCE_FORMAT, {5'd0, lwpbe_pkg::SRC_444}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'hF00F0F, 0, '0));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'h0F000A, 0, '0));
		// 4-4-4 panel
		plan.push_back(cfg_row(lwpbe_pkg::REG_PANEL_FORMAT, {6'd0, lwpbe_pkg::PANEL_444}));
		plan.push_back(cfg_row(lwpbe_pkg::REG_SOURCE_FORMAT, {5'd0, lwpbe_pkg::SRC_8BIT}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'hFFFFFF, 2,
			{8'h0F, 8'hFF, 72'h0}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'h808080, 0, '0));
		plan.push_back(cfg_row(lwpbe_pkg::REG_SOURCE_FORMAT, {5'd0, lwpbe_pkg::SRC_444}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'hABCDEF, 2,
			{8'hCD, 8'hEF, 72'h0}));
		// unused codes fall back to 5-6-5 panel and 8-bit source
		plan.push_back(cfg_row(lwpbe_pkg::REG_PANEL_FORMAT, {6'd0, PANEL_SPARE}));
		plan.push_back(cfg_row(lwpbe_pkg::REG_SOURCE_FORMAT, {5'd0, SRC_SPARE}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'hFFFFFF, 2,
			{8'hFF, 8'hFF, 72'h0}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'h00FF00, 0, '0));
		// 5-6-5 passthrough ignores the swap
		plan.push_back(cfg_row(lwpbe_pkg::REG_PANEL_FORMAT, {6'd0, lwpbe_pkg::PANEL_565}));
		plan.push_back(cfg_row(lwpbe_pkg::REG_SOURCE_FORMAT, {5'd0, lwpbe_pkg::SRC_565}));
		plan.push_back(item_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 24'h00BEEF, 2,
			{8'hBE, 8'hEF, 72'h0}));
		// junk in upper register bits, and a write to a spare index
		plan.push_back(cfg_row(lwpbe_pkg::REG_PANEL_FORMAT, 8'hFC));
		plan.push_back(cfg_row(lwpbe_pkg::REG_SOURCE_FORMAT, 8'hF9));
		plan.push_back(cfg_row(lwpbe_pkg::REG_BLUE_FIRST, 8'hFE));
		plan.push_back(cfg_row(REG_SPARE_LAST, 8'h55));
		plan.push_back(item_row(ACT_PIXEL, 8'h11, 8'h22, 8'h33, 8'h44, 24'h3264C8, 0, '0));
		plan.push_back(item_row(ACT_WINDOW, 8'h80, 8'h7F, 8'h00, 8'hFE, 24'hC0FFEE, 0, '0));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// directed table
		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cfg) begin
				drain_stream();
				write_reg(row.reg_idx, row.reg_data);
			end else begin
				idle_sender();
				offer_item(row.act, row.cs, row.rs, row.ce, row.re, row.colour,
					row.n_typed, row.typed);
			end
		end
		n_directed = items_sent;

		// random phases, each under fresh register settings
		phase = 0;
		while (items_sent < n_directed + RANDOM_ITEMS) begin
			drain_stream();
			if (n_directed + RANDOM_ITEMS - items_sent <= QUIET_TAIL_ITEMS)
				no_idle = 1'b1;
			write_reg(lwpbe_pkg::REG_PANEL_FORMAT, reg_value(8'h03));
			write_reg(lwpbe_pkg::REG_SOURCE_FORMAT, reg_value(8'h07));
			write_reg(lwpbe_pkg::REG_BLUE_FIRST, reg_value(8'h01));
			write_reg(lwpbe_pkg::REG_COLUMN_OFFSET, pick_byte());
			write_reg(lwpbe_pkg::REG_ROW_OFFSET, pick_byte());
			if ($urandom_range(0, 3) == 0)
				write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 8'($urandom));
			burst = $urandom_range(8, 16);
			// second phase: receiver holds off while the sender keeps pushing
			if (phase == 1) begin
				hold_request = 1'b1;
				burst = PRESSURE_ITEMS;
			end
			for (int i = 0; i < burst; i++) begin
				// third phase: pause mid-way until the stream is empty
				if (phase == 2 && i == burst / 2)
					drain_stream();
				if (phase != 1)
					idle_sender();
				offer_item(($urandom_range(0, 9) == 0) ? ACT_WINDOW : ACT_PIXEL,
					pick_byte(), pick_byte(), pick_byte(), pick_byte(),
					{pick_channel(), pick_channel(), pick_channel()}, 0, '0);
			end
			phase++;
		end

		drain_stream();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
